@@ hdl/rec_pkg.sv @@
// ----------------------------------------------------------------------------
// rec_pkg: shared types and constants of the range encoder
// Holds the channel payloads, the command passed from front to back, the
// operation codes, the back-end state type and the coder constants.
// ----------------------------------------------------------------------------
package rec_pkg;

   localparam int WORD_W            = 32;
   localparam int BYTE_W            = 8;
   localparam int OP_W              = 2;
   localparam int CUM_W             = 16;
   localparam int FRQ_W             = 16;
   localparam int TOT_W             = 17;
   localparam int FREQ_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int PTR_W             = $clog2(QUEUE_DEPTH);
   localparam int FLUSH_STEPS       = 5;
   localparam int STEP_W            = 3;

   localparam logic [WORD_W-1:0] TOP_LIMIT   = 32'h0100_0000;
   localparam logic [WORD_W-1:0] CARRY_LIMIT = 32'hFF00_0000;
   localparam logic [BYTE_W-1:0] RUN_BYTE_NO_CARRY = 8'hFF;
   localparam logic [BYTE_W-1:0] RUN_BYTE_CARRY    = 8'h00;

   typedef enum logic [OP_W-1:0] {
      OP_ENCODE  = 2'd0,
      OP_FLUSH   = 2'd1,
      OP_RESTART = 2'd2
   } rec_op_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CUM_W-1:0] cum_freq;
      logic [FRQ_W-1:0] sym_freq;
      logic [TOT_W-1:0] total_freq;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic [WORD_W-1:0] repeat_count;
      logic              last_of_run;
   } rsp_payload_type;

   // Command handed from the front to the back; frequencies are already masked.
   typedef struct packed {
      rec_op_type       kind;
      logic [CUM_W-1:0] cum_freq;
      logic [FRQ_W-1:0] sym_freq;
      logic [TOT_W-1:0] total_freq;
   } rec_cmd_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_MULTIPLY,
      BACK_UPDATE,
      BACK_STEP,
      BACK_RUN,
      BACK_FINISH
   } rec_back_state_type;

endpackage

@@ hdl/rec_stream_if.sv @@
// ----------------------------------------------------------------------------
// rec_stream_if: valid/ready stream channel
// Carries one payload per accepted item; the source drives valid and payload,
// the sink drives ready.
// ----------------------------------------------------------------------------
interface rec_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/rec_front.sv @@
// ----------------------------------------------------------------------------
// rec_front: request intake and command queue
// Masks the frequency fields, drops items that do nothing, and queues the
// remaining commands for the back end in a short first-in first-out buffer.
// ----------------------------------------------------------------------------
module rec_front import rec_pkg::*; #(
   parameter int FREQ_BITS = FREQ_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output rec_cmd_type     cmd
);

   localparam int CNT_W = PTR_W + 1;
   localparam logic [CUM_W-1:0] CUM_MASK = CUM_W'((32'd1 << FREQ_BITS) - 32'd1);
   localparam logic [FRQ_W-1:0] FRQ_MASK = FRQ_W'((32'd1 << FREQ_BITS) - 32'd1);
   localparam logic [TOT_W-1:0] TOT_MASK = TOT_W'((32'd1 << (FREQ_BITS + 1)) - 32'd1);

   rec_cmd_type      queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   rec_cmd_type cmd_new;
   logic        keep;
   logic        push;
   logic        pop;

   // Classification: an encode with a zero frequency and the unused opcode
   // leave the coder untouched, so they are consumed here.
   always_comb begin
      cmd_new.kind       = OP_ENCODE;
      cmd_new.cum_freq   = req_payload.cum_freq & CUM_MASK;
      cmd_new.sym_freq   = req_payload.sym_freq & FRQ_MASK;
      cmd_new.total_freq = req_payload.total_freq & TOT_MASK;
      keep               = 1'b0;
      unique case (req_payload.op)
         OP_ENCODE: begin
            keep = (cmd_new.sym_freq != '0) && (cmd_new.total_freq != '0);
         end
         OP_FLUSH: begin
            cmd_new.kind = OP_FLUSH;
            keep         = 1'b1;
         end
         OP_RESTART: begin
            cmd_new.kind = OP_RESTART;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   assign push = req_valid && req_ready && keep;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/rec_back.sv @@
// ----------------------------------------------------------------------------
// rec_back: coder datapath and result output
// Runs one command at a time: a bit-serial division of the range by the
// total, the two products, the interval update, then the renormalization
// steps that retire bytes through the cache and the pending run.
// ----------------------------------------------------------------------------
module rec_back import rec_pkg::*; #(
   parameter int FREQ_BITS = FREQ_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   output logic            cmd_ready,
   input  rec_cmd_type     cmd,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int DIV_W  = FREQ_BITS + 1;
   localparam int PROD_W = WORD_W + FREQ_BITS;
   localparam int CNT_W  = $clog2(WORD_W);

   rec_back_state_type state_ff, state_in;

   logic [WORD_W-1:0]    low_ff, low_in;
   logic [WORD_W-1:0]    range_ff, range_in;
   logic [WORD_W-1:0]    pending_ff, pending_in;
   logic [BYTE_W-1:0]    cached_ff, cached_in;
   logic                 carry_ff, carry_in;

   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [FREQ_BITS-1:0] cum_ff, cum_in;
   logic [FREQ_BITS-1:0] frq_ff, frq_in;
   logic [WORD_W-1:0]    off_ff, off_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;

   rsp_payload_type      hold_ff, hold_in;
   logic                 hold_valid_ff, hold_valid_in;
   rsp_payload_type      out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic                 out_free;
   logic                 can_emit;
   logic                 renorm_cond;
   logic [DIV_W:0]       trial;
   logic                 trial_ge;
   logic [WORD_W-1:0]    rng_sat;
   logic [WORD_W:0]      low_sum;
   logic                 emit;
   rsp_payload_type      emit_item;

   // A finished result waits in the hold register until the next one shows
   // up or the command ends, which is when its end-of-run mark is known.
   assign out_free    = !out_valid_ff || rsp_ready;
   assign can_emit    = !hold_valid_ff || out_free;
   assign renorm_cond = (low_ff < CARRY_LIMIT) || carry_ff;
   assign trial       = {rem_ff, quo_ff[WORD_W-1]};
   assign trial_ge    = (trial >= {1'b0, div_ff});
   assign rng_sat     = (prod_ff[PROD_W-1:WORD_W] != '0) ? '1 : prod_ff[WORD_W-1:0];
   assign low_sum     = {1'b0, low_ff} + {1'b0, off_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               priority if (cmd.kind == OP_ENCODE) begin
                  state_in = BACK_DIVIDE;
               end else if (cmd.kind == OP_FLUSH) begin
                  state_in = BACK_STEP;
               end else begin
                  state_in = BACK_IDLE;
               end
            end
         end
         BACK_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = BACK_MULTIPLY;
            end
         end
         BACK_MULTIPLY: begin
            state_in = BACK_UPDATE;
         end
         BACK_UPDATE: begin
            state_in = BACK_STEP;
         end
         BACK_STEP: begin
            if (steps_ff == '0) begin
               state_in = BACK_FINISH;
            end else if (renorm_cond && can_emit && (pending_ff != '0)) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (can_emit) begin
               state_in = BACK_STEP;
            end
         end
         BACK_FINISH: begin
            if (!hold_valid_ff || out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      cmd_ready     = (state_ff == BACK_IDLE);
      rsp_valid     = out_valid_ff;
      rsp_payload   = out_ff;

      low_in        = low_ff;
      range_in      = range_ff;
      pending_in    = pending_ff;
      cached_in     = cached_ff;
      carry_in      = carry_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      cnt_in        = cnt_ff;
      cum_in        = cum_ff;
      frq_in        = frq_ff;
      off_in        = off_ff;
      prod_in       = prod_ff;
      steps_in      = steps_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      emit          = 1'b0;
      emit_item     = '0;

      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               priority if (cmd.kind == OP_ENCODE) begin
                  quo_in = range_ff;
                  rem_in = '0;
                  div_in = cmd.total_freq[DIV_W-1:0];
                  cum_in = cmd.cum_freq[FREQ_BITS-1:0];
                  frq_in = cmd.sym_freq[FREQ_BITS-1:0];
                  cnt_in = CNT_W'(WORD_W - 1);
               end else if (cmd.kind == OP_FLUSH) begin
                  steps_in = STEP_W'(FLUSH_STEPS);
               end else begin
                  low_in     = '0;
                  range_in   = '1;
                  pending_in = '0;
                  cached_in  = '0;
                  carry_in   = 1'b0;
               end
            end
         end
         BACK_DIVIDE: begin
            // Restoring division, one quotient bit per cycle.
            if (trial_ge) begin
               rem_in = DIV_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = trial[DIV_W-1:0];
            end
            quo_in = {quo_ff[WORD_W-2:0], trial_ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         BACK_MULTIPLY: begin
            off_in  = quo_ff * WORD_W'(cum_ff);
            prod_in = PROD_W'(quo_ff) * PROD_W'(frq_ff);
         end
         BACK_UPDATE: begin
            low_in   = low_sum[WORD_W-1:0];
            carry_in = carry_ff | low_sum[WORD_W];
            // The range shifts by one byte per renormalization step.
            priority if (rng_sat[31:24] != '0) begin
               range_in = rng_sat;
               steps_in = STEP_W'(0);
            end else if (rng_sat[23:16] != '0) begin
               range_in = rng_sat << 8;
               steps_in = STEP_W'(1);
            end else if (rng_sat[15:8] != '0) begin
               range_in = rng_sat << 16;
               steps_in = STEP_W'(2);
            end else begin
               range_in = rng_sat << 24;
               steps_in = STEP_W'(3);
            end
         end
         BACK_STEP: begin
            if (steps_ff != '0) begin
               if (renorm_cond) begin
                  emit                 = 1'b1;
                  emit_item.byte_value = cached_ff + BYTE_W'(carry_ff);
                  emit_item.repeat_count = WORD_W'(1);
                  if (can_emit && (pending_ff == '0)) begin
                     cached_in = low_ff[31:24];
                     carry_in  = 1'b0;
                     low_in    = low_ff << 8;
                     steps_in  = steps_ff - STEP_W'(1);
                  end
               end else begin
                  // Top byte may still take a carry: defer it to the run.
                  pending_in = pending_ff + WORD_W'(1);
                  low_in     = low_ff << 8;
                  steps_in   = steps_ff - STEP_W'(1);
               end
            end
         end
         BACK_RUN: begin
            emit                   = 1'b1;
            emit_item.byte_value   = carry_ff ? RUN_BYTE_CARRY : RUN_BYTE_NO_CARRY;
            emit_item.repeat_count = pending_ff;
            if (can_emit) begin
               pending_in = '0;
               cached_in  = low_ff[31:24];
               carry_in   = 1'b0;
               low_in     = low_ff << 8;
               steps_in   = steps_ff - STEP_W'(1);
            end
         end
         BACK_FINISH: begin
            if (hold_valid_ff && out_free) begin
               out_in             = hold_ff;
               out_in.last_of_run = 1'b1;
               out_valid_in       = 1'b1;
               hold_valid_in      = 1'b0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      if (emit && can_emit) begin
         if (hold_valid_ff) begin
            out_in             = hold_ff;
            out_in.last_of_run = 1'b0;
            out_valid_in       = 1'b1;
         end
         hold_in       = emit_item;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      cum_ff   <= cum_in;
      frq_ff   <= frq_in;
      off_ff   <= off_in;
      prod_ff  <= prod_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         low_ff        <= '0;
         range_ff      <= '1;
         pending_ff    <= '0;
         cached_ff     <= '0;
         carry_ff      <= 1'b0;
         steps_ff      <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         low_ff        <= low_in;
         range_ff      <= range_in;
         pending_ff    <= pending_in;
         cached_ff     <= cached_in;
         carry_ff      <= carry_in;
         steps_ff      <= steps_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_IDLE |-> !hold_valid_ff)
      else $error("result left in hold register between commands");

   a_run_has_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_RUN |-> pending_ff != '0)
      else $error("pending run emitted with zero count");

   a_range_normalized: assert property (@(posedge clock) disable iff (reset)
      range_ff >= TOP_LIMIT)
      else $error("range left below renormalization limit");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == BACK_DIVIDE |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= STEP_W'(FLUSH_STEPS) || state_ff == BACK_DIVIDE
      || state_ff == BACK_MULTIPLY)
      else $error("renormalization step count out of range");

endmodule

@@ hdl/range_encoder_carry.sv @@
// ----------------------------------------------------------------------------
// range_encoder_carry: 32-bit byte-oriented range encoder with carry
// An encode passes through dequeue, the bit-serial divider, the product,
// the update, the renormalization steps and finish; a flush runs only the
// renormalization steps and finish, and a restart only the dequeue. The
// back part takes the next command only once it is done with the last one.
// Reset is synchronous and active high; the coder comes out of reset in its
// initial state and the command queue and output register are empty.
// ----------------------------------------------------------------------------
module range_encoder_carry import rec_pkg::*; #(
   parameter int FREQ_BITS = FREQ_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   rec_stream_if.sink   req_ch,
   rec_stream_if.source rsp_ch
);

   // The front part takes one request item per cycle while the queue has
   // room. Encodes with a zero frequency and the unused opcode produce no
   // result and no state change, so the front consumes them on the spot.
   // The queue holds two commands so requests keep flowing while the back
   // part divides.
   logic        cmd_valid;
   logic        cmd_ready;
   rec_cmd_type cmd;

   rec_front #(
      .FREQ_BITS (FREQ_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // The back part owns the coder state. Each renormalization step that
   // settles the top byte gives the cached byte plus carry and, when bytes
   // are pending, one item that stands for the whole run of 0xFF or 0x00
   // bytes. Results leave through an output register, so the back part keeps
   // working while the consumer stalls, until a second result is waiting.
   rec_back #(
      .FREQ_BITS (FREQ_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload)
   );

endmodule

@@ sim/range_encoder_carry_tb.sv @@
// ----------------------------------------------------------------------------
// range_encoder_carry_tb: self-checking bench for the carry range encoder
// Drives encode, flush and restart items into the request channel in random
// bursts and keeps a cycle-free model of the coder state in step with every
// accepted item. Each result item is compared field by field with the oldest
// predicted byte run, while the response side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module range_encoder_carry_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rec_pkg::*;

   // The encoding space has one code that the block must drop silently.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int MAX_PRINTED  = 200;    // mismatch lines shown before going quiet
   localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the final drain
   localparam int TAIL_CYCLES  = 60;     // longer than the slowest encode
   localparam int RANDOM_ITEMS = 110;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   rec_stream_if #(.payload_type(req_payload_type)) req_if ();
   rec_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   range_encoder_carry dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // -------------------------------------------------------------------------
   // Coder model. These variables mirror the encoder state; they advance once
   // per accepted request item, and every byte run that item produces is
   // appended to expected_bytes in output order.
   // -------------------------------------------------------------------------
   logic [WORD_W-1:0] coder_low;
   logic [WORD_W-1:0] coder_range;
   logic [WORD_W-1:0] coder_pending;
   logic [BYTE_W-1:0] coder_cache;
   logic              coder_carry;

   rsp_payload_type expected_bytes[$];

   int mismatch_count = 0;
   int burst_left     = 1;

   function automatic void reset_coder();
      coder_low     = '0;
      coder_range   = '1;
      coder_pending = '0;
      coder_cache   = '0;
      coder_carry   = 1'b0;
   endfunction

   function automatic void push_byte(input logic [BYTE_W-1:0] value,
                                     input logic [WORD_W-1:0] count);
      rsp_payload_type run;
      run.byte_value   = value;
      run.repeat_count = count;
      run.last_of_run  = 1'b0;
      expected_bytes.push_back(run);
   endfunction

   // One renormalization step: the top byte of low either goes to the cache
   // (releasing the old cached byte and any pending run, corrected by the
   // carry) or, when it may still be hit by a carry, is held back as pending.
   function automatic void retire_byte();
      if (coder_low < CARRY_LIMIT || coder_carry) begin
         push_byte(coder_cache + BYTE_W'(coder_carry), 32'd1);
         if (coder_pending != '0) begin
            push_byte(coder_carry ? RUN_BYTE_CARRY : RUN_BYTE_NO_CARRY, coder_pending);
            coder_pending = '0;
         end
         coder_cache = coder_low[31:24];
         coder_carry = 1'b0;
      end else begin
         coder_pending = coder_pending + WORD_W'(1);
      end
      coder_low = coder_low << 8;
   endfunction

   // Advances the model by one request item. With FREQ_BITS at its default
   // the frequency fields already have the masked widths, so no masking is
   // needed here.
   function automatic void predict_encoder_output(input req_payload_type item);
      int                first_new;
      logic [WORD_W-1:0] offset;
      logic [WORD_W:0]   low_sum;
      logic [63:0]       product;
      first_new = expected_bytes.size();
      case (item.op)
         OP_ENCODE: begin
            // A symbol with no probability mass leaves the coder untouched.
            if (item.sym_freq != '0 && item.total_freq != '0) begin
               coder_range = coder_range / WORD_W'(item.total_freq);
               offset      = coder_range * WORD_W'(item.cum_freq);   // wraps mod 2^32
               low_sum     = {1'b0, coder_low} + {1'b0, offset};
               // The carry flag is sticky: a second wrap keeps it at one.
               if (low_sum[WORD_W])
                  coder_carry = 1'b1;
               coder_low = low_sum[WORD_W-1:0];
               product   = 64'(coder_range) * 64'(item.sym_freq);
               // Only a symbol wider than the total can overflow; clamp it.
               coder_range = (product[63:32] != '0) ? '1 : product[31:0];
               while (coder_range < TOP_LIMIT) begin
                  coder_range = coder_range << 8;
                  retire_byte();
               end
            end
         end
         OP_FLUSH: begin
            repeat (FLUSH_STEPS) retire_byte();
         end
         OP_RESTART: begin
            reset_coder();
         end
         default: begin
            // The unused code is dropped without any effect.
         end
      endcase
      if (expected_bytes.size() > first_new)
         expected_bytes[$].last_of_run = 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Reporting and checking.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic check_output_byte(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected result item: byte %02h count %0d last %0b",
                                   got.byte_value, got.repeat_count, got.last_of_run));
         return;
      end
      want = expected_bytes.pop_front();
      if (got.byte_value !== want.byte_value)
         report_mismatch($sformatf("byte_value %02h, expected %02h",
                                   got.byte_value, want.byte_value));
      if (got.repeat_count !== want.repeat_count)
         report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                   got.repeat_count, want.repeat_count));
      if (got.last_of_run !== want.last_of_run)
         report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                   got.last_of_run, want.last_of_run));
   endtask

   // The response side samples accepted items at the clock edge and picks its
   // stall pattern from bits 10:9 of its cycle counter: always ready, mostly
   // ready, ready while the low three counter bits are zero, and rarely ready.
   // This puts back-pressure on every phase of the encoder's output sequence.
   logic [15:0] sink_cycle;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_cycle   <= '0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_output_byte(rsp_if.payload);
         sink_cycle <= sink_cycle + 16'd1;
         case (sink_cycle[10:9])
            2'd0:    rsp_if.ready <= 1'b1;
            2'd1:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_if.ready <= (sink_cycle[2:0] == 3'd0);
            default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Request side.
   // -------------------------------------------------------------------------
   function automatic req_payload_type make_item(input logic [OP_W-1:0]  op,
                                                 input logic [CUM_W-1:0] cum,
                                                 input logic [FRQ_W-1:0] sym,
                                                 input logic [TOT_W-1:0] total);
      req_payload_type item;
      item.op         = op;
      item.cum_freq   = cum;
      item.sym_freq   = sym;
      item.total_freq = total;
      return item;
   endfunction

   // Presents one item and holds it until the encoder takes it. Valid stays
   // high across the items of a burst; when a burst ends it drops for a
   // random, nonzero gap, so a lowering and a raising never share a step.
   task automatic send_item(input req_payload_type item);
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do
         @(posedge clock);
      while (!req_if.ready);
      predict_encoder_output(item);
      burst_left--;
      if (burst_left <= 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
      end
   endtask

   // Holds the request side off until every predicted result has come back.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // Extreme field values. The first encode keeps the full range, the second
   // uses the widest fields, the last two divide by the largest total so that
   // several renormalizations follow and the top one produces a pending byte.
   task automatic test_field_extremes();
      send_item(make_item(OP_ENCODE, 16'h0000, 16'h0001, 17'h00001));
      send_item(make_item(OP_ENCODE, 16'hFFFF, 16'hFFFF, 17'h10000));
      send_item(make_item(OP_ENCODE, 16'h0000, 16'h0001, 17'h10000));
      send_item(make_item(OP_RESTART, 16'hFFFF, 16'hFFFF, 17'h1FFFF));
      send_item(make_item(OP_ENCODE, 16'hFFFF, 16'h0001, 17'h10000));
      send_item(make_item(OP_FLUSH, 16'h0000, 16'h0000, 17'h00000));
   endtask

   // Flush straight out of a restart gives the all-zero byte stream; a second
   // flush shows the state after five shifts.
   task automatic test_flush_restart();
      send_item(make_item(OP_RESTART, 16'h0000, 16'h0000, 17'h00000));
      send_item(make_item(OP_FLUSH, 16'h1234, 16'h5678, 17'h09ABC));
      send_item(make_item(OP_FLUSH, 16'hFFFF, 16'hFFFF, 17'h1FFFF));
   endtask

   // The unused code and encodes with a zero frequency must neither change
   // the coder nor produce anything; the final flush exposes the state.
   task automatic test_ignored_items();
      send_item(make_item(OP_ENCODE, 16'h00FF, 16'h0010, 17'h00100));
      send_item(make_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 17'h1FFFF));
      send_item(make_item(OP_ENCODE, 16'h0001, 16'h0000, 17'h00100));
      send_item(make_item(OP_ENCODE, 16'h0001, 16'h0010, 17'h00000));
      send_item(make_item(OP_ENCODE, 16'hFFFF, 16'h0000, 17'h00000));
      send_item(make_item(OP_FLUSH, 16'h0000, 16'h0000, 17'h00000));
   endtask

   // A symbol frequency above the total makes the new range exceed 32 bits,
   // which must clamp to all ones.
   task automatic test_range_saturation();
      send_item(make_item(OP_RESTART, 16'h0000, 16'h0000, 17'h00000));
      send_item(make_item(OP_ENCODE, 16'h0000, 16'hFFFF, 17'h00001));
      send_item(make_item(OP_ENCODE, 16'h0002, 16'hFFFF, 17'h00003));
      send_item(make_item(OP_FLUSH, 16'h0000, 16'h0000, 17'h00000));
   endtask

   // With a total of one the range stays at all ones and low moves down by
   // cum each time, so low wraps on the second and again on the third encode
   // before any renormalization clears the carry.
   task automatic test_second_carry();
      send_item(make_item(OP_RESTART, 16'h0000, 16'h0000, 17'h00000));
      repeat (3) send_item(make_item(OP_ENCODE, 16'hFFFF, 16'h0001, 17'h00001));
      send_item(make_item(OP_ENCODE, 16'h0000, 16'h0001, 17'h10000));
      send_item(make_item(OP_FLUSH, 16'h0000, 16'h0000, 17'h00000));
   endtask

   // Builds a pending byte and then lets a carry fall on it: low is set near
   // the top, one renormalization holds its 0xFF byte back, and a wrapping
   // encode follows, so the pending run must come out as 0x00.
   task automatic test_carry_into_pending();
      send_item(make_item(OP_RESTART, 16'h0000, 16'h0000, 17'h00000));
      send_item(make_item(OP_ENCODE, 16'hFF01, 16'h0001, 17'h00001));
      send_item(make_item(OP_ENCODE, 16'h0000, 16'h0001, 17'h00100));
      send_item(make_item(OP_ENCODE, 16'h0100, 16'h0001, 17'h00001));
      send_item(make_item(OP_FLUSH, 16'h0000, 16'h0000, 17'h00000));
   endtask

   // Random stream. Most items are well-formed encodes (cum + freq within the
   // total) so the coder keeps a realistic state and runs into carries and
   // pending runs; a third of those pick the top symbol to push low upward.
   // The rest are flushes, restarts, dropped items and malformed encodes.
   // Dropped items do not count toward coded_items.
   task automatic test_random_stream(input int coded_items);
      int  done;
      int  pick;
      int  total;
      int  sym;
      int  cum;
      bit  paused;
      done   = 0;
      paused = 1'b0;
      while (done < coded_items) begin
         // Halfway through, wait for the output to run dry once.
         if (!paused && done >= coded_items / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 3))
               0:       total = $urandom_range(1, 16);
               1:       total = $urandom_range(17, 4096);
               2:       total = $urandom_range(1, 65536);
               default: total = 65536;
            endcase
            sym = $urandom_range(1, (total > 65535) ? 65535 : total);
            cum = ($urandom_range(0, 2) == 0) ? total - sym : $urandom_range(0, total - sym);
            send_item(make_item(OP_ENCODE, CUM_W'(cum), FRQ_W'(sym), TOT_W'(total)));
            done++;
         end else if (pick < 78) begin
            send_item(make_item(OP_FLUSH, CUM_W'($urandom), FRQ_W'($urandom),
                                TOT_W'($urandom)));
            done++;
         end else if (pick < 82) begin
            send_item(make_item(OP_RESTART, CUM_W'($urandom), FRQ_W'($urandom),
                                TOT_W'($urandom)));
            done++;
         end else if (pick < 86) begin
            send_item(make_item(OP_UNUSED, CUM_W'($urandom), FRQ_W'($urandom),
                                TOT_W'($urandom)));
         end else if (pick < 90) begin
            if ($urandom_range(0, 1) == 0)
               send_item(make_item(OP_ENCODE, CUM_W'($urandom), 16'h0000,
                                   TOT_W'($urandom)));
            else
               send_item(make_item(OP_ENCODE, CUM_W'($urandom), FRQ_W'($urandom),
                                   17'h00000));
         end else begin
            // Unconstrained encode: any cum, and a total that may exceed 2^16.
            send_item(make_item(OP_ENCODE, CUM_W'($urandom),
                                FRQ_W'($urandom_range(1, 65535)),
                                TOT_W'($urandom_range(1, 131071))));
            done++;
         end
      end
   endtask

   // Lets the last results come back, then gives the encoder time to finish
   // anything still in flight so a stray extra item would be caught.
   task automatic finish_run();
      int waited;
      req_if.valid <= 1'b0;
      waited = 0;
      while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d expected result items never arrived",
                                   expected_bytes.size()));
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   endtask

   // -------------------------------------------------------------------------
   // Sequence of tests.
   // -------------------------------------------------------------------------
   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      reset_coder();
      burst_left = $urandom_range(1, 8);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      wait_for_drain();
      test_flush_restart();
      test_ignored_items();
      wait_for_drain();
      test_range_saturation();
      test_second_carry();
      test_carry_into_pending();
      test_random_stream(RANDOM_ITEMS);
      finish_run();
   end

   // Guard against a hang: far beyond the slowest legal run, in which every
   // item takes the longest encode and each of its results waits out the
   // sparsest stall pattern.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ range_encoder_carry.f @@
hdl/rec_pkg.sv
hdl/rec_stream_if.sv
hdl/rec_front.sv
hdl/rec_back.sv
hdl/range_encoder_carry.sv
sim/range_encoder_carry_tb.sv
